[design/thsh_pkg.sv]
// Shared constants and types of the thermistor temperature converter.
package thsh_pkg;

  // Register map of the configuration port.
  typedef enum logic [1:0] {
    REG_SERIES = 2'd0,
    REG_COEF_A = 2'd1,
    REG_COEF_B = 2'd2,
    REG_COEF_C = 2'd3
  } cfg_reg_t;

  // Side information that travels with every item down the pipeline.
  typedef struct packed {
    logic        bad;
    logic [11:0] code;
  } thsh_tag_t;

  localparam int unsigned ADC_FULL_SCALE_DEF = 4096;

  localparam logic [19:0] SERIES_RST = 20'd200000;
  localparam logic [35:0] COEF_A_RST = 36'd4058065905;
  localparam logic [35:0] COEF_B_RST = 36'd4168749254;
  localparam logic [35:0] COEF_C_RST = 36'd2223021;

  // ln 2 in Q.30 and 273.15 in Q.16.
  localparam int LN2_Q30        = 744261118;
  localparam int KELVIN_OFS_Q16 = 17901158;
  localparam int TEMP_MIN       = -300;
  localparam int TEMP_MAX       = 2000;

endpackage

[design/thermistor_steinhart_hart_converter_core.sv]
// Pipelined Steinhart-Hart converter from thermistor ADC code to degrees Celsius.
// Throughput: one item per cycle; the whole pipeline advances whenever the output
// register is empty or being taken, so a stall on the output holds every stage.
// The longest parts are the 30 squaring stages of the logarithm and the 61 bit-serial
// stages of the reciprocal. Synchronous active-low reset empties the pipeline and
// loads the registers with their default values.
module thermistor_steinhart_hart_converter_core #(
  parameter int unsigned ADC_FULL_SCALE = thsh_pkg::ADC_FULL_SCALE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,     // [11:0] adc_code
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,    // [11:0] temp_celsius, [23:12] raw_code
  output logic [0:0]  out_tuser,    // [0] fault
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);
  import thsh_pkg::*;

  localparam int FS_W   = $clog2(ADC_FULL_SCALE + 1);
  localparam int RW1    = FS_W + 1;
  localparam int NUM_W  = 48;
  localparam int D1_STP = 4;
  localparam int D1S    = NUM_W / D1_STP;
  localparam int SQN    = 30;
  localparam int Q2_W   = 61;
  localparam int DV2_W  = 53;
  localparam int ST_LZ  = D1S + 1;
  localparam int ST_SQ0 = ST_LZ + 1;
  localparam int ST_LN  = ST_SQ0 + SQN + 1;
  localparam int ST_AB  = ST_LN + 1;
  localparam int ST_M1  = ST_AB + 1;
  localparam int ST_M8  = ST_M1 + 7;
  localparam int ST_D20 = ST_M8 + 1;
  localparam int ST_CV  = ST_D20 + Q2_W + 1;
  localparam int ST_OUT = ST_CV + 1;
  localparam int NST    = ST_OUT + 1;
  localparam logic signed [36:0] LN2_S   = 37'(LN2_Q30);
  localparam logic signed [61:0] CEL_OFS = 62'(KELVIN_OFS_Q16 - 32768);

  logic        en;
  logic        wr;
  logic [19:0] series_r;
  logic [35:0] coef_a_r, coef_b_r, coef_c_r;

  logic      v_r   [NST];
  thsh_tag_t tag_r [NST];
  thsh_tag_t in_tag;

  // Configuration registers.
  assign wr         = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      series_r <= SERIES_RST;
      coef_a_r <= COEF_A_RST;
      coef_b_r <= COEF_B_RST;
      coef_c_r <= COEF_C_RST;
    end else if (wr) begin
      unique case (cfg_reg_t'(cfg_paddr[4:3]))
        REG_SERIES: series_r <= cfg_pwdata[19:0];
        REG_COEF_A: coef_a_r <= cfg_pwdata[35:0];
        REG_COEF_B: coef_b_r <= cfg_pwdata[35:0];
        REG_COEF_C: coef_c_r <= cfg_pwdata[35:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_reg_t'(cfg_paddr[4:3]))
      REG_SERIES: cfg_prdata = 64'(series_r);
      REG_COEF_A: cfg_prdata = 64'(coef_a_r);
      REG_COEF_B: cfg_prdata = 64'(coef_b_r);
      REG_COEF_C: cfg_prdata = 64'(coef_c_r);
      default:    cfg_prdata = '0;
    endcase
  end

  // Global advance: the output register is the only point where the pipeline waits.
  assign en        = !v_r[ST_OUT] || out_tready;
  assign in_tready = en;

  // Input stage: range check, numerator and divisor of the resistance.
  logic [11:0]     code;
  logic            in_range;
  logic [FS_W-1:0] dv_in;
  logic [31:0]     prod_in;

  assign code     = in_tdata[11:0];
  assign in_range = (code != 12'd0) && (32'(code) < 32'(ADC_FULL_SCALE));
  assign dv_in    = in_range ? FS_W'(32'(ADC_FULL_SCALE) - 32'(code)) : FS_W'(1);
  assign prod_in  = 32'(series_r) * 32'(code);
  assign in_tag   = '{bad: !in_range || (series_r == 20'd0), code: code};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NST; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_tvalid;
      for (int i = 1; i < NST; i++) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_r[0] <= in_tag;
      for (int i = 1; i < NST; i++) tag_r[i] <= tag_r[i-1];
    end
  end

  // Resistance in Q.16: restoring division, four quotient bits per stage.
  logic [RW1-1:0]   d1_rem_r [D1S+1];
  logic [NUM_W-1:0] d1_q_r   [D1S+1];
  logic [FS_W-1:0]  d1_dv_r  [D1S+1];
  logic [RW1-1:0]   d1_rem_nxt [D1S+1];
  logic [NUM_W-1:0] d1_q_nxt   [D1S+1];

  always_comb begin
    logic [RW1-1:0]   rem;
    logic [NUM_W-1:0] q;
    d1_rem_nxt[0] = '0;
    d1_q_nxt[0]   = {prod_in, 16'd0};
    for (int i = 1; i <= D1S; i++) begin
      rem = d1_rem_r[i-1];
      q   = d1_q_r[i-1];
      for (int j = 0; j < D1_STP; j++) begin
        rem = {rem[RW1-2:0], q[NUM_W-1]};
        q   = {q[NUM_W-2:0], 1'b0};
        if (rem >= {1'b0, d1_dv_r[i-1]}) begin
          rem  = rem - {1'b0, d1_dv_r[i-1]};
          q[0] = 1'b1;
        end
      end
      d1_rem_nxt[i] = rem;
      d1_q_nxt[i]   = q;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_dv_r[0] <= dv_in;
      for (int i = 0; i <= D1S; i++) begin
        d1_rem_r[i] <= d1_rem_nxt[i];
        d1_q_r[i]   <= d1_q_nxt[i];
      end
      for (int i = 1; i <= D1S; i++) d1_dv_r[i] <= d1_dv_r[i-1];
    end
  end

  // Leading one of the resistance.
  logic [NUM_W-1:0] lz_r_r;
  logic [5:0]       lz_p_r;
  logic [5:0]       lz_p_nxt;

  always_comb begin
    lz_p_nxt = '0;
    for (int k = 0; k < NUM_W; k++) begin
      if (d1_q_r[D1S][k]) lz_p_nxt = 6'(k);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lz_r_r <= d1_q_r[D1S];
      lz_p_r <= lz_p_nxt;
    end
  end

  // Fraction of log2 by repeated squaring of the Q1.30 mantissa, one square a stage.
  logic [30:0]    sq_m_r [SQN+1];
  logic [SQN-1:0] sq_f_r [SQN+1];
  logic [5:0]     sq_p_r [SQN+1];
  logic [30:0]    sq_m_nxt [SQN+1];
  logic [SQN-1:0] sq_f_nxt [SQN+1];

  always_comb begin
    logic [61:0] sq;
    if (lz_p_r >= 6'd30) sq_m_nxt[0] = 31'(lz_r_r >> (lz_p_r - 6'd30));
    else                 sq_m_nxt[0] = 31'(lz_r_r[30:0] << (6'd30 - lz_p_r));
    sq_f_nxt[0] = '0;
    for (int k = 1; k <= SQN; k++) begin
      sq = {31'd0, sq_m_r[k-1]} * {31'd0, sq_m_r[k-1]};
      if (sq[61]) begin
        sq_m_nxt[k] = sq[61:31];
        sq_f_nxt[k] = {sq_f_r[k-1][SQN-2:0], 1'b1};
      end else begin
        sq_m_nxt[k] = sq[60:30];
        sq_f_nxt[k] = {sq_f_r[k-1][SQN-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_p_r[0] <= lz_p_r;
      for (int k = 0; k <= SQN; k++) begin
        sq_m_r[k] <= sq_m_nxt[k];
        sq_f_r[k] <= sq_f_nxt[k];
      end
      for (int k = 1; k <= SQN; k++) sq_p_r[k] <= sq_p_r[k-1];
    end
  end

  // Natural log: integer part times ln 2 plus fraction times ln 2.
  logic signed [36:0] ln_pl_r;
  logic [29:0]        ln_fl_r;
  logic signed [6:0]  ps;
  logic [59:0]        fm;

  assign ps = $signed({1'b0, sq_p_r[SQN]}) - 7'sd16;
  assign fm = 60'(sq_f_r[SQN]) * 60'(LN2_Q30);

  always_ff @(posedge clk) begin
    if (en) begin
      ln_pl_r <= 37'(ps) * LN2_S;
      ln_fl_r <= fm[59:30];
    end
  end

  logic signed [36:0] lval;
  logic [36:0]        lmag;
  logic [34:0]        ab_lm_r;
  logic               ab_neg_r;

  assign lval = ln_pl_r + $signed({7'd0, ln_fl_r});
  assign lmag = lval[36] ? 37'(-lval) : 37'(lval);

  always_ff @(posedge clk) begin
    if (en) begin
      ab_lm_r  <= lmag[34:0];
      ab_neg_r <= lval[36];
    end
  end

  // Polynomial B*|L| + C*|L|^3, wide products split into two partial products.
  logic [52:0] m1_p2a_r;
  logic [51:0] m1_p2b_r;
  logic [53:0] m1_pba_r;
  logic [52:0] m1_pbb_r;
  logic [34:0] m1_lm_r, m2_lm_r;
  logic        m1_neg_r, m2_neg_r, m3_neg_r, m4_neg_r, m5_neg_r, m6_neg_r, m7_neg_r;
  logic [39:0] m2_l2_r;
  logic [40:0] m2_tb_r, m3_tb_r, m4_tb_r, m5_tb_r, m6_tb_r;
  logic [57:0] m3_p3a_r;
  logic [56:0] m3_p3b_r;
  logic [44:0] m4_l3_r;
  logic [58:0] m5_p4a_r;
  logic [57:0] m5_p4b_r;
  logic [50:0] m6_tc_r;
  logic [51:0] m7_s_r;
  logic signed [53:0] m8_d_r;
  logic [69:0] sum2;
  logic [70:0] sumb;
  logic [74:0] sum3;
  logic [80:0] sum4;

  assign sum2 = 70'(m1_p2a_r) + (70'(m1_p2b_r) << 18);
  assign sumb = 71'(m1_pba_r) + (71'(m1_pbb_r) << 18);
  assign sum3 = 75'(m3_p3a_r) + (75'(m3_p3b_r) << 18);
  assign sum4 = 81'(m5_p4a_r) + (81'(m5_p4b_r) << 23);

  always_ff @(posedge clk) begin
    if (en) begin
      m1_p2a_r <= 53'(ab_lm_r) * 53'(ab_lm_r[17:0]);
      m1_p2b_r <= 52'(ab_lm_r) * 52'(ab_lm_r[34:18]);
      m1_pba_r <= 54'(coef_b_r) * 54'(ab_lm_r[17:0]);
      m1_pbb_r <= 53'(coef_b_r) * 53'(ab_lm_r[34:18]);
      m1_lm_r  <= ab_lm_r;
      m1_neg_r <= ab_neg_r;

      m2_l2_r  <= sum2[69:30];
      m2_tb_r  <= sumb[70:30];
      m2_lm_r  <= m1_lm_r;
      m2_neg_r <= m1_neg_r;

      m3_p3a_r <= 58'(m2_l2_r) * 58'(m2_lm_r[17:0]);
      m3_p3b_r <= 57'(m2_l2_r) * 57'(m2_lm_r[34:18]);
      m3_tb_r  <= m2_tb_r;
      m3_neg_r <= m2_neg_r;

      m4_l3_r  <= sum3[74:30];
      m4_tb_r  <= m3_tb_r;
      m4_neg_r <= m3_neg_r;

      m5_p4a_r <= 59'(coef_c_r) * 59'(m4_l3_r[22:0]);
      m5_p4b_r <= 58'(coef_c_r) * 58'(m4_l3_r[44:23]);
      m5_tb_r  <= m4_tb_r;
      m5_neg_r <= m4_neg_r;

      m6_tc_r  <= sum4[80:30];
      m6_tb_r  <= m5_tb_r;
      m6_neg_r <= m5_neg_r;

      m7_s_r   <= 52'(m6_tb_r) + 52'(m6_tc_r);
      m7_neg_r <= m6_neg_r;

      m8_d_r   <= m7_neg_r ? $signed(54'(coef_a_r) - 54'(m7_s_r))
                           : $signed(54'(coef_a_r) + 54'(m7_s_r));
    end
  end

  // Kelvin in Q.16 = 2^60 / D: restoring division, one quotient bit per stage.
  logic              d_pos;
  logic [DV2_W:0]    d2_rem_r [Q2_W+1];
  logic [Q2_W-1:0]   d2_q_r   [Q2_W+1];
  logic [DV2_W-1:0]  d2_dv_r  [Q2_W+1];
  logic              d2_pos_r [Q2_W+1];
  logic [DV2_W:0]    d2_rem_nxt [Q2_W+1];
  logic [Q2_W-1:0]   d2_q_nxt   [Q2_W+1];

  assign d_pos = !m8_d_r[53] && (m8_d_r != 54'sd0);

  always_comb begin
    logic [DV2_W:0]  rem;
    logic [Q2_W-1:0] q;
    d2_rem_nxt[0] = '0;
    d2_q_nxt[0]   = {1'b1, {(Q2_W-1){1'b0}}};
    for (int i = 1; i <= Q2_W; i++) begin
      rem = {d2_rem_r[i-1][DV2_W-1:0], d2_q_r[i-1][Q2_W-1]};
      q   = {d2_q_r[i-1][Q2_W-2:0], 1'b0};
      if (rem >= {1'b0, d2_dv_r[i-1]}) begin
        rem  = rem - {1'b0, d2_dv_r[i-1]};
        q[0] = 1'b1;
      end
      d2_rem_nxt[i] = rem;
      d2_q_nxt[i]   = q;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2_dv_r[0]  <= d_pos ? m8_d_r[DV2_W-1:0] : DV2_W'(1);
      d2_pos_r[0] <= d_pos;
      for (int i = 0; i <= Q2_W; i++) begin
        d2_rem_r[i] <= d2_rem_nxt[i];
        d2_q_r[i]   <= d2_q_nxt[i];
      end
      for (int i = 1; i <= Q2_W; i++) begin
        d2_dv_r[i]  <= d2_dv_r[i-1];
        d2_pos_r[i] <= d2_pos_r[i-1];
      end
    end
  end

  // Celsius rounded half up, then saturation and fault selection.
  logic signed [61:0] vk;
  logic signed [45:0] cv_c_r;
  logic               cv_pos_r;
  logic [11:0]        temp_r;
  logic               fault_r;
  logic [11:0]        temp_nxt;
  logic               fault_nxt;

  assign vk = $signed({1'b0, d2_q_r[Q2_W]}) - CEL_OFS;

  always_ff @(posedge clk) begin
    if (en) begin
      cv_c_r   <= 46'(vk >>> 16);
      cv_pos_r <= d2_pos_r[Q2_W];
    end
  end

  always_comb begin
    priority if (tag_r[ST_CV].bad) begin
      temp_nxt  = '0;
      fault_nxt = 1'b1;
    end else if (!cv_pos_r || cv_c_r > 46'(TEMP_MAX)) begin
      temp_nxt  = 12'(TEMP_MAX);
      fault_nxt = 1'b1;
    end else if (cv_c_r < 46'(TEMP_MIN)) begin
      temp_nxt  = 12'(TEMP_MIN);
      fault_nxt = 1'b1;
    end else begin
      temp_nxt  = cv_c_r[11:0];
      fault_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      temp_r  <= temp_nxt;
      fault_r <= fault_nxt;
    end
  end

  assign out_tvalid = v_r[ST_OUT];
  assign out_tdata  = {tag_r[ST_OUT].code, temp_r};
  assign out_tuser  = fault_r;

  // A result without fault lies inside the temperature range.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |->
      ($signed(out_tdata[11:0]) >= 12'(TEMP_MIN)) && ($signed(out_tdata[11:0]) <= 12'(TEMP_MAX)))
    else $error("fault clear on an out-of-range temperature");

  // A zero or full-scale code always reports a fault.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ((out_tdata[23:12] == 12'd0) ||
                   (32'(out_tdata[23:12]) >= 32'(ADC_FULL_SCALE))) |-> out_tuser[0])
    else $error("bad code without fault");

  // A stalled output freezes the whole pipeline, so nothing is accepted.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(v_r[ST_CV]) && $stable(cv_c_r))
    else $error("pipeline moved during an output stall");

  // Reset empties the pipeline.
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid straight after reset");

endmodule
